// ===== rtl/wdc_pkg.sv =====
// ----------------------------------------------------------------------------
// wdc_pkg
// Shared types and constants for the waypoint to drive command unit.
// ----------------------------------------------------------------------------
package wdc_pkg;

   // result command codes
   typedef enum logic [2:0] {
      CMD_LEFT    = 3'd0,
      CMD_RIGHT   = 3'd1,
      CMD_FORWARD = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_SHORT   = 3'd4
   } cmd_code_type;

   // configuration register indexes
   localparam logic [1:0] REG_DRIVE_SPEED = 2'd0;
   localparam logic [1:0] REG_ROT_SCALE   = 2'd1;
   localparam logic [1:0] REG_LIN_SCALE   = 2'd2;

   localparam int SPEED_WIDTH = 8;
   localparam int SCALE_WIDTH = 24;
   localparam int AMOUNT_WIDTH = 32;

   localparam logic signed [SPEED_WIDTH-1:0] SPEED_RESET = 8'sd50;
   localparam logic [SCALE_WIDTH-1:0]        SCALE_RESET = 24'd65536;

   // 1 / CORDIC gain as a 0.32 fraction
   localparam logic [31:0] GAIN_INV = 32'h9B74EDA8;
   localparam int DEG_TURN = 360;

   localparam int ATAN_LEN = 24;
   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TAB [0:ATAN_LEN-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ITER,
      ST_MUL1,
      ST_LEN,
      ST_MUL2,
      ST_MUL3,
      ST_FIN,
      ST_SPIN,
      ST_FWD,
      ST_STOP,
      ST_SHORT
   } state_type;

   typedef enum logic [1:0] {
      OUT_SPIN,
      OUT_FWD,
      OUT_STOP,
      OUT_SHORT
   } out_kind_type;

   typedef struct packed {
      logic         load;
      logic         prep;
      logic         keep_point;
      logic         iter;
      logic         mul1;
      logic         len;
      logic         first_seg;
      logic         mul2;
      logic         mul3;
      logic         fin;
      out_kind_type out_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic iter_done;
      logic spin_nz;
   } dp_status_type;

endpackage

// ===== rtl/waypoint_to_drive_commands_unit.sv =====
// ----------------------------------------------------------------------------
// waypoint_to_drive_commands_unit
// Turns polyline waypoints into spin, forward and stop commands.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                 | tuser / tlast
//  req_    | in  | point_x, point_y                   | path_start, path_end
//  rsp_    | out | command, motor_speed, amount       | tlast = last_of_run
//  csr_    | in  | we, index, wdata                   | -
//
//  The first result is offered after an accepted item has passed the PREP,
//  ITER (the shared CORDIC iteration), MUL1, LEN, MUL2, MUL3 and FIN states,
//  then one result per cycle while rsp_tready is high (up to three). A lone
//  first point or one-point path goes from PREP straight to idle or SHORT.
//  Reset (synchronous) clears path state and loads register defaults.
//  req_tready is low from acceptance until the last result is taken.
// ----------------------------------------------------------------------------
module waypoint_to_drive_commands_unit #(
   parameter int COORD_WIDTH  = 24,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_x, point_y
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // path_start, path_end
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // command, motor_speed, amount
   output logic [47:0]                        rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [wdc_pkg::SCALE_WIDTH-1:0]    csr_wdata
);
   import wdc_pkg::*;

   logic signed [SPEED_WIDTH-1:0] drive_speed_ff;
   logic [SCALE_WIDTH-1:0]        rot_scale_ff, lin_scale_ff;
   dp_cmd_type                    cmd;
   dp_status_type                 status;
   logic [2:0]                    command;
   logic signed [SPEED_WIDTH-1:0] motor_speed;
   logic [AMOUNT_WIDTH-1:0]       amount;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_speed_ff <= SPEED_RESET;
         rot_scale_ff   <= SCALE_RESET;
         lin_scale_ff   <= SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DRIVE_SPEED: drive_speed_ff <= csr_wdata[SPEED_WIDTH-1:0];
            REG_ROT_SCALE:   rot_scale_ff   <= csr_wdata;
            REG_LIN_SCALE:   lin_scale_ff   <= csr_wdata;
            default:         drive_speed_ff <= drive_speed_ff;
         endcase
      end
   end

   wdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .path_start (req_tuser[0]),
      .path_end   (req_tuser[1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   wdc_datapath #(
      .COORD_WIDTH  (COORD_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .point_x          (req_tdata[COORD_WIDTH-1:0]),
      .point_y          (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .drive_speed      (drive_speed_ff),
      .rotational_scale (rot_scale_ff),
      .linear_scale     (lin_scale_ff),
      .cmd              (cmd),
      .status           (status),
      .command          (command),
      .motor_speed      (motor_speed),
      .amount           (amount)
   );

   assign rsp_tdata = {5'd0, amount, motor_speed, command};

   // one item in flight: never taking a new item while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input taken while result pending");

   a_stop_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] == CMD_STOP || rsp_tdata[2:0] == CMD_SHORT))
      |-> rsp_tlast)
      else $error("stop or short result not last of run");

   a_spin_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] == CMD_LEFT || rsp_tdata[2:0] == CMD_RIGHT))
      |-> !rsp_tlast)
      else $error("spin marked last of run");

   a_reset_regs: assert property (@(posedge clock)
      $past(reset) |-> (drive_speed_ff == SPEED_RESET && rot_scale_ff == SCALE_RESET))
      else $error("register defaults lost after reset");

endmodule

// ===== rtl/wdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdc_ctrl
// Sequencer: path flags, CORDIC/multiply sequencing and result emission.
// ----------------------------------------------------------------------------
module wdc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   path_start,
   input  logic                   path_end,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_tlast,
   output wdc_pkg::dp_cmd_type    cmd,
   input  wdc_pkg::dp_status_type status
);
   import wdc_pkg::*;

   state_type state_ff, state_in;
   logic have_point_ff, have_point_in;
   logic have_heading_ff, have_heading_in;
   logic run_ff, run_in;
   logic first_ff, first_in;
   logic end_ff, end_in;
   logic accept;
   logic hp_eff, hh_eff;

   assign accept = req_tvalid && req_tready;
   assign hp_eff = have_point_ff && !path_start;
   assign hh_eff = have_heading_ff && !path_start;

   always_comb begin
      have_point_in   = have_point_ff;
      have_heading_in = have_heading_ff;
      run_in          = run_ff;
      first_in        = first_ff;
      end_in          = end_ff;
      if (accept) begin
         run_in          = hp_eff;
         first_in        = !hh_eff;
         end_in          = path_end;
         have_point_in   = !path_end;
         have_heading_in = !path_end && (hh_eff || hp_eff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_PREP;
         ST_PREP: begin
            if (run_ff)      state_in = ST_ITER;
            else if (end_ff) state_in = ST_SHORT;
            else             state_in = ST_IDLE;
         end
         ST_ITER:  if (status.iter_done) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_LEN;
         ST_LEN:   state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_FIN;
         ST_FIN:   state_in = status.spin_nz ? ST_SPIN : ST_FWD;
         ST_SPIN:  if (rsp_tready) state_in = ST_FWD;
         ST_FWD:   if (rsp_tready) state_in = end_ff ? ST_STOP : ST_IDLE;
         ST_STOP:  if (rsp_tready) state_in = ST_IDLE;
         ST_SHORT: if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.keep_point = !end_ff;
      cmd.first_seg  = first_ff;
      cmd.out_kind   = OUT_FWD;
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      rsp_tlast      = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_PREP: cmd.prep = 1'b1;
         ST_ITER: cmd.iter = 1'b1;
         ST_MUL1: cmd.mul1 = 1'b1;
         ST_LEN:  cmd.len  = 1'b1;
         ST_MUL2: cmd.mul2 = 1'b1;
         ST_MUL3: cmd.mul3 = 1'b1;
         ST_FIN:  cmd.fin  = 1'b1;
         ST_SPIN: begin
            rsp_tvalid   = 1'b1;
            cmd.out_kind = OUT_SPIN;
         end
         ST_FWD: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = !end_ff;
         end
         ST_STOP: begin
            rsp_tvalid   = 1'b1;
            rsp_tlast    = 1'b1;
            cmd.out_kind = OUT_STOP;
         end
         ST_SHORT: begin
            rsp_tvalid   = 1'b1;
            rsp_tlast    = 1'b1;
            cmd.out_kind = OUT_SHORT;
         end
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         have_point_ff   <= 1'b0;
         have_heading_ff <= 1'b0;
         run_ff          <= 1'b0;
         first_ff        <= 1'b0;
         end_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         have_point_ff   <= have_point_in;
         have_heading_ff <= have_heading_in;
         run_ff          <= run_in;
         first_ff        <= first_in;
         end_ff          <= end_in;
      end
   end

endmodule

// ===== rtl/wdc_datapath.sv =====
// ----------------------------------------------------------------------------
// wdc_datapath
// Segment delta, iterative CORDIC vectoring, length and turn scaling.
// ----------------------------------------------------------------------------
module wdc_datapath #(
   parameter int COORD_WIDTH  = 24,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic signed [COORD_WIDTH-1:0]             point_x,
   input  logic signed [COORD_WIDTH-1:0]             point_y,
   input  logic signed [wdc_pkg::SPEED_WIDTH-1:0]    drive_speed,
   input  logic [wdc_pkg::SCALE_WIDTH-1:0]           rotational_scale,
   input  logic [wdc_pkg::SCALE_WIDTH-1:0]           linear_scale,
   input  wdc_pkg::dp_cmd_type                       cmd,
   output wdc_pkg::dp_status_type                    status,
   output logic [2:0]                                command,
   output logic signed [wdc_pkg::SPEED_WIDTH-1:0]    motor_speed,
   output logic [wdc_pkg::AMOUNT_WIDTH-1:0]          amount
);
   import wdc_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int AW  = ANGLE_WIDTH;
   localparam int XW  = CW + 11;          // delta * 256, folded, plus CORDIC growth
   localparam int IW  = $clog2(CORDIC_STEPS);
   localparam int L3W = XW + 9;           // length * 360
   localparam int FHW = L3W - 16 + SCALE_WIDTH;
   localparam int FLW = 16 + SCALE_WIDTH;
   localparam int SPW = AW + 9;
   localparam int SSW = SPW + SCALE_WIDTH;

   logic signed [CW-1:0]  x_ff, y_ff, px_ff, py_ff;
   logic signed [XW-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]           z_ff, z_in;
   logic                  zero_ff, zero_in;
   logic [IW-1:0]         i_ff;
   logic [63:0]           lg_ff, hg_ff;
   logic [XW-1:0]         len_ff;
   logic [AW-1:0]         ph_ff, dmag_ff;
   logic                  spin_nz_ff, left_ff;
   logic [L3W-1:0]        len360_ff;
   logic [SPW-1:0]        spinp_ff;
   logic [FHW-1:0]        fh_ff;
   logic [FLW-1:0]        fl_ff;
   logic [SSW-1:0]        sp_ff;
   logic [31:0]           fwd_ff, spin_ff;

   logic signed [CW:0]    dx, dy;
   logic signed [XW-1:0]  dxe, dye, xs, ys;
   logic [63:0]           mag64, len_full, t64, tt;
   logic [31:0]           zr;
   logic [AW-1:0]         hd, d, dmag;

   // segment delta scaled by 256, left half-plane folded by a half turn
   always_comb begin
      dx      = (CW+1)'(x_ff) - (CW+1)'(px_ff);
      dy      = (CW+1)'(y_ff) - (CW+1)'(py_ff);
      dxe     = XW'(dx) <<< 8;
      dye     = XW'(dy) <<< 8;
      zero_in = (dx == '0) && (dy == '0);
      if (dx < 0) begin
         cx_in = -dxe;
         cy_in = -dye;
         z_in  = 32'h80000000;
      end else begin
         cx_in = dxe;
         cy_in = dye;
         z_in  = 32'h0;
      end
   end

   assign xs = cx_ff >>> i_ff;
   assign ys = cy_ff >>> i_ff;
   assign status.iter_done = (i_ff == IW'(CORDIC_STEPS - 1));

   assign mag64    = cx_ff[XW-1] ? 64'd0 : 64'(unsigned'(cx_ff));
   assign len_full = hg_ff + (lg_ff >> 32);
   assign zr       = z_ff + (32'd1 << (31 - AW));
   assign hd       = zero_ff ? '0 : zr[31 -: AW];
   assign d        = cmd.first_seg ? '0 : hd - ph_ff;
   assign dmag     = d[AW-1] ? -d : d;
   assign t64      = 64'(fh_ff) + 64'(fl_ff >> 16);
   assign tt       = t64 >> 16;

   assign status.spin_nz   = spin_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
      end else if (cmd.prep) begin
         i_ff <= '0;
      end else if (cmd.iter && !status.iter_done) begin
         i_ff <= i_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= point_x;
         y_ff <= point_y;
      end
      if (cmd.prep) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         z_ff    <= z_in;
         zero_ff <= zero_in;
         if (cmd.keep_point) begin
            px_ff <= x_ff;
            py_ff <= y_ff;
         end
      end
      if (cmd.iter) begin
         if (!cy_ff[XW-1]) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            z_ff  <= z_ff + ATAN_TAB[5'(i_ff)];
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            z_ff  <= z_ff - ATAN_TAB[5'(i_ff)];
         end
      end
      if (cmd.mul1) begin
         lg_ff <= 64'(mag64[31:0]) * 64'(GAIN_INV);
         hg_ff <= 64'(mag64[63:32]) * 64'(GAIN_INV);
      end
      if (cmd.len) begin
         len_ff     <= zero_ff ? '0 : XW'(len_full);
         ph_ff      <= hd;
         dmag_ff    <= dmag;
         spin_nz_ff <= (d != '0);
         left_ff    <= (d != '0) && !d[AW-1];
      end
      if (cmd.mul2) begin
         len360_ff <= L3W'(len_ff) * L3W'(DEG_TURN);
         spinp_ff  <= SPW'(dmag_ff) * SPW'(DEG_TURN);
      end
      if (cmd.mul3) begin
         fh_ff <= FHW'(len360_ff[L3W-1:16]) * FHW'(linear_scale);
         fl_ff <= FLW'(len360_ff[15:0]) * FLW'(linear_scale);
         sp_ff <= SSW'(spinp_ff) * SSW'(rotational_scale);
      end
      if (cmd.fin) begin
         fwd_ff  <= (|tt[63:32]) ? 32'hFFFFFFFF : tt[31:0];
         spin_ff <= 32'(sp_ff[SSW-1:AW+16]);
      end
   end

   always_comb begin
      case (cmd.out_kind)
         OUT_SPIN: begin
            command     = left_ff ? CMD_LEFT : CMD_RIGHT;
            motor_speed = drive_speed;
            amount      = spin_ff;
         end
         OUT_FWD: begin
            command     = CMD_FORWARD;
            motor_speed = drive_speed;
            amount      = fwd_ff;
         end
         OUT_STOP: begin
            command     = CMD_STOP;
            motor_speed = '0;
            amount      = '0;
         end
         OUT_SHORT: begin
            command     = CMD_SHORT;
            motor_speed = '0;
            amount      = '0;
         end
         default: begin
            command     = CMD_SHORT;
            motor_speed = '0;
            amount      = '0;
         end
      endcase
   end

endmodule

// ===== bench/waypoint_to_drive_commands_unit_test.sv =====
// ----------------------------------------------------------------------------
// waypoint_to_drive_commands_unit_test
// Self-checking bench for the waypoint to drive command unit. Waypoints are
// streamed in as directed paths and then as random paths. A local model
// computes the spin, forward, stop and path too short commands for each
// accepted point, and every result item is checked against it in order.
// The sender and the receiver stall at random. Registers change between
// phases, when the unit is idle.
// ----------------------------------------------------------------------------
module waypoint_to_drive_commands_unit_test;
   import wdc_pkg::*;

   localparam int CW = 24;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      cmd_code_type             cmd;
      logic signed [7:0]        speed;
      logic [31:0]              amount;
      logic                     last;
   } drive_cmd_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   waypoint_to_drive_commands_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // model registers and path state
   logic signed [7:0] speed_reg;
   logic [23:0]       rot_reg;
   logic [23:0]       lin_reg;
   longint            last_x;
   longint            last_y;
   logic [15:0]       last_heading;
   bit                point_held;
   bit                heading_held;

   drive_cmd_type pending_cmds[$];
   int            fail_count;
   int            tx_idle_pct;
   int            rx_idle_pct;
   int            cycle_count;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // --- prediction ----------------------------------------------------------

   function automatic void segment_geometry(input longint dx, input longint dy,
                                            output logic [15:0] heading,
                                            output bit [63:0] length);
      longint    cx;
      longint    cy;
      longint    xs;
      longint    ys;
      bit [31:0] z;
      bit [63:0] rounded;
      bit [63:0] mag;
      if (dx == 0 && dy == 0) begin
         heading = '0;
         length = '0;
         return;
      end
      cx = dx * 256;
      cy = dy * 256;
      z = '0;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         z = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx += ys;
            cy -= xs;
            z += ATAN_TAB[i];
         end else begin
            cx -= ys;
            cy += xs;
            z -= ATAN_TAB[i];
         end
      end
      rounded = (64'(z) + 64'd32768) >> 16;
      heading = rounded[15:0];
      mag = (cx > 0) ? 64'(cx) : 64'd0;
      length = (mag >> 32) * 64'(GAIN_INV)
               + (((mag & 64'hFFFFFFFF) * 64'(GAIN_INV)) >> 32);
   endfunction

   function automatic logic [31:0] saturate(input bit [63:0] v);
      return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
   endfunction

   function automatic void queue_cmd(input cmd_code_type cmd, input logic signed [7:0] spd,
                                     input logic [31:0] amt);
      drive_cmd_type c;
      c.cmd = cmd;
      c.speed = spd;
      c.amount = amt;
      c.last = 1'b0;
      pending_cmds.push_back(c);
   endfunction

   function automatic void predict_commands(input logic signed [CW-1:0] px,
                                            input logic signed [CW-1:0] py,
                                            input bit start, input bit stop);
      logic [15:0] hd;
      logic [15:0] diff;
      bit [63:0]   len;
      bit [63:0]   len360;
      bit [63:0]   turn;
      bit [63:0]   fwd_amt;
      int          n;
      n = 0;
      if (start) begin
         point_held = 0;
         heading_held = 0;
      end
      if (point_held) begin
         segment_geometry(longint'(px) - last_x, longint'(py) - last_y, hd, len);
         if (!heading_held) begin
            last_heading = hd;
            heading_held = 1;
         end
         diff = hd - last_heading;
         if (diff != 0) begin
            turn = (diff >= 16'h8000) ? 64'd65536 - 64'(diff) : 64'(diff);
            turn = (turn * 64'd360 * 64'(rot_reg)) >> 32;
            queue_cmd((diff >= 16'h8000) ? CMD_RIGHT : CMD_LEFT, speed_reg, saturate(turn));
            n++;
         end
         last_heading = hd;
         len360 = len * 64'd360;
         fwd_amt = (len360 >> 16) * 64'(lin_reg)
                   + (((len360 & 64'hFFFF) * 64'(lin_reg)) >> 16);
         queue_cmd(CMD_FORWARD, speed_reg, saturate(fwd_amt >> 16));
         n++;
         if (stop) begin
            queue_cmd(CMD_STOP, '0, '0);
            n++;
         end
      end else if (stop) begin
         queue_cmd(CMD_SHORT, '0, '0);
         n++;
      end
      if (stop) begin
         point_held = 0;
         heading_held = 0;
      end else begin
         last_x = longint'(px);
         last_y = longint'(py);
         point_held = 1;
      end
      if (n > 0)
         pending_cmds[$].last = 1'b1;
   endfunction

   // --- result checking -----------------------------------------------------

   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result item: tdata %h tlast %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_tdata[2:0] !== want.cmd || rsp_tdata[10:3] !== want.speed
                || rsp_tdata[42:11] !== want.amount || rsp_tlast !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: cmd %0d/%0d speed %0d/%0d amount %0d/%0d last %b/%b",
                           want.cmd, rsp_tdata[2:0], want.speed, $signed(rsp_tdata[10:3]),
                           want.amount, rsp_tdata[42:11], want.last, rsp_tlast);
            end
         end
      end
   end

   // --- stimulus helpers ----------------------------------------------------

   task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                             input bit start, input bit stop);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {px, py} == 0 ? '0 : {py, px};
      req_tuser = {stop, start};
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      predict_commands(px, py, start, stop);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain;
      while (pending_cmds.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         REG_DRIVE_SPEED: speed_reg = value[7:0];
         REG_ROT_SCALE:   rot_reg = value;
         REG_LIN_SCALE:   lin_reg = value;
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic signed [7:0] spd, input logic [23:0] rot,
                           input logic [23:0] lin);
      drain();
      write_reg(REG_DRIVE_SPEED, {16'h0, spd});
      write_reg(REG_ROT_SCALE, rot);
      write_reg(REG_LIN_SCALE, lin);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2, 3: return CW'($signed($urandom_range(8191)) - 4096);
         default: return CW'($urandom);
      endcase
   endfunction

   // --- tests ---------------------------------------------------------------

   task automatic test_special_cases;
      send_point(24'sd0, 24'sd0, 1'b0, 1'b1);          // one-point path
      send_point(24'sd0, 24'sd0, 1'b1, 1'b0);          // lone first point: no result
      send_point(24'sd256, 24'sd0, 1'b0, 1'b0);        // first segment, no spin
      send_point(24'sd0, 24'sd0, 1'b0, 1'b0);          // exact half turn
      send_point(24'sd0, 24'sd0, 1'b0, 1'b0);          // zero-length segment
      send_point(24'sd0, 24'sd256, 1'b0, 1'b0);        // spin left
      send_point(24'sd256, 24'sd0, 1'b0, 1'b1);        // spin right, then stop
      send_point(24'sd512, 24'sd512, 1'b0, 1'b0);      // new path without a start flag
      send_point(-24'sd300, 24'sd100, 1'b0, 1'b1);
   endtask

   task automatic test_extremes;
      send_point(24'sh800000, 24'sh800000, 1'b1, 1'b0);
      send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0);
      send_point(24'sh800000, 24'sh7FFFFF, 1'b0, 1'b0);
      send_point(24'sh7FFFFF, 24'sh800000, 1'b0, 1'b0);
      send_point(24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0); // restart mid-path
      send_point(24'sh800000, 24'sh800000, 1'b0, 1'b0);
      send_point(24'sh000001, -24'sh000001, 1'b0, 1'b1);
      send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b1);
   endtask

   task automatic test_random_paths(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 8) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) begin
               send_point(rand_coord(), rand_coord(), i == 0, i == len - 1);
               sent++;
            end
         end else begin
            send_point(rand_coord(), rand_coord(), $urandom_range(1), $urandom_range(1));
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      cycle_count = 0;
      tx_idle_pct = 11;
      rx_idle_pct = 83;
      speed_reg = SPEED_RESET;
      rot_reg = SCALE_RESET;
      lin_reg = SCALE_RESET;
      point_held = 0;
      heading_held = 0;
      last_x = 0;
      last_y = 0;
      last_heading = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_special_cases();
      test_extremes();
      set_regs(8'sd100, 24'hFFFFFF, 24'hFFFFFF);
      write_reg(2'd3, 24'hFFFFFF);                      // unmapped index, ignored
      test_extremes();
      set_regs(-8'sd100, 24'd0, 24'd0);
      test_special_cases();

      set_regs(8'sd37, 24'd98304, 24'd40000);
      test_random_paths(63);
      tx_idle_pct = 83;
      rx_idle_pct = 11;
      set_regs(-8'sd5, 24'd1000000, 24'd300);
      test_random_paths(63);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_regs(8'($signed($urandom_range(200)) - 100), 24'($urandom), 24'($urandom));
      test_random_paths(60);

      drain();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
